### src/tds_pkg.sv
package tds_pkg;

   typedef struct packed {
      logic [11:0] first_year;
      logic [3:0]  first_month;
      logic [4:0]  first_day;
      logic [4:0]  first_hour;
      logic [5:0]  first_minute;
      logic [5:0]  first_second;
      logic [11:0] second_year;
      logic [3:0]  second_month;
      logic [4:0]  second_day;
      logic [4:0]  second_hour;
      logic [5:0]  second_minute;
      logic [5:0]  second_second;
   } tds_req_type;

   typedef struct packed {
      logic signed [32:0] seconds_difference;
      logic [1:0]         order;
   } tds_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YEAR,
      ST_LEAP,
      ST_CENT,
      ST_QUAD,
      ST_DOY,
      ST_SCALE,
      ST_TIME,
      ST_DONE
   } tds_state_type;

   typedef struct packed {
      logic clear;
      logic add;
      logic negate;
      logic scale;
   } tds_acc_ctl_type;

   localparam int AccWidth  = 40;
   localparam int DayWidth  = 22;
   localparam int TermWidth = 21;

   localparam logic [7:0]  DeadbandReset = 8'd10;
   localparam logic [16:0] SecsPerDay    = 17'd86400;
   localparam logic [11:0] SecsPerHour   = 12'd3600;

   localparam logic signed [AccWidth-1:0] DiffMax = 40'sd4294967295;
   localparam logic signed [AccWidth-1:0] DiffMin = -40'sd4294967296;

   localparam logic [1:0] OrderEqual       = 2'd0;
   localparam logic [1:0] OrderSecondLater = 2'd1;
   localparam logic [1:0] OrderFirstLater  = 2'd2;

   // Exact floor(x / 100) for every 13-bit x up to 4494.
   function automatic logic [6:0] div100(input logic [12:0] x);
      logic [25:0] prod;
      prod = x * 13'd5243;
      return prod[25:19];
   endfunction

   // Days of the whole months that precede the given month in a common year.
   function automatic logic [8:0] cum_days(input logic [3:0] month);
      logic [8:0] days;
      unique case (month)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         4'd13,
         4'd14,
         4'd15:   days = 9'd365;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

### src/tds_accum.sv
module tds_accum (
   input  logic                                  clock,
   input  tds_pkg::tds_acc_ctl_type              ctl,
   input  logic [tds_pkg::TermWidth-1:0]         term,
   output logic signed [tds_pkg::AccWidth-1:0]   acc
);
   import tds_pkg::*;

   logic signed [AccWidth-1:0] acc_ff;
   logic signed [AccWidth-1:0] acc_in;
   logic signed [AccWidth-1:0] term_ext;
   logic signed [DayWidth-1:0] days;
   logic signed [DayWidth+17:0] prod;

   assign term_ext = signed'({{(AccWidth-TermWidth){1'b0}}, term});
   assign days     = acc_ff[DayWidth-1:0];
   assign prod     = days * signed'({1'b0, SecsPerDay});

   always_comb begin
      priority if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.scale) begin
         acc_in = AccWidth'(prod);
      end else if (ctl.add) begin
         acc_in = ctl.negate ? acc_ff - term_ext : acc_ff + term_ext;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### src/timestamp_difference_seconds.sv
// A sequencer drives a single add/subtract accumulator, one step per cycle: the day count
// of each timestamp, one scaling multiply to seconds, then the time of day of each.
// The input stalls while an item is in work, so a new item is taken only after the last,
// and the final step waits while a previous result has not been transferred.
// Reset (synchronous, active high) returns to idle, drops the result valid and
// loads the deadband register with 10.
module timestamp_difference_seconds (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tds_pkg::tds_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tds_pkg::tds_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);
   import tds_pkg::*;

   tds_state_type   state_ff, state_in;
   logic            side_ff, side_in;
   logic [6:0]      quot_ff, quot_in;
   logic            leap_ff, leap_in;
   logic [7:0]      deadband_ff;
   logic            rsp_valid_ff;
   tds_rsp_type     rsp_data_ff;
   tds_rsp_type     rsp_data_in;
   tds_req_type     item_ff;
   logic            load_rsp;

   tds_acc_ctl_type             acc_ctl;
   logic [TermWidth-1:0]        term;
   logic signed [AccWidth-1:0]  acc;

   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;

   logic [AccWidth-1:0] mag;
   logic [37:0]         first_key;
   logic [37:0]         second_key;
   logic [32:0]         rsp_mag;

   tds_accum u_accum (
      .clock (clock),
      .ctl   (acc_ctl),
      .term  (term),
      .acc   (acc)
   );

   // The second timestamp is added first, then the first one is subtracted.
   always_comb begin
      if (side_ff) begin
         year   = item_ff.first_year;
         month  = item_ff.first_month;
         day    = item_ff.first_day;
         hour   = item_ff.first_hour;
         minute = item_ff.first_minute;
         second = item_ff.first_second;
      end else begin
         year   = item_ff.second_year;
         month  = item_ff.second_month;
         day    = item_ff.second_day;
         hour   = item_ff.second_hour;
         minute = item_ff.second_minute;
         second = item_ff.second_second;
      end
   end

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      quot_in  = quot_ff;
      leap_in  = leap_ff;
      acc_ctl  = '0;
      term     = '0;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            acc_ctl.clear = 1'b1;
            if (req_valid) begin
               side_in  = 1'b0;
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            quot_in        = div100({1'b0, year});
            term           = TermWidth'(year) * TermWidth'(9'd365);
            acc_ctl.add    = 1'b1;
            acc_ctl.negate = side_ff;
            state_in       = ST_LEAP;
         end
         ST_LEAP: begin
            leap_in = (year[1:0] == 2'd0) &&
                      (({2'b0, year} != 14'(quot_ff) * 14'd100) || (quot_ff[1:0] == 2'd0));
            quot_in        = div100({1'b0, year} + 13'd99);
            term           = TermWidth'(({1'b0, year} + 13'd3) >> 2);
            acc_ctl.add    = 1'b1;
            acc_ctl.negate = side_ff;
            state_in       = ST_CENT;
         end
         ST_CENT: begin
            quot_in        = div100(({1'b0, year} + 13'd399) >> 2);
            term           = TermWidth'(quot_ff);
            acc_ctl.add    = 1'b1;
            acc_ctl.negate = !side_ff;
            state_in       = ST_QUAD;
         end
         ST_QUAD: begin
            term           = TermWidth'(quot_ff);
            acc_ctl.add    = 1'b1;
            acc_ctl.negate = side_ff;
            state_in       = ST_DOY;
         end
         ST_DOY: begin
            term = TermWidth'(cum_days(month)) + TermWidth'(leap_ff && (month >= 4'd3))
                 + TermWidth'(day);
            acc_ctl.add    = 1'b1;
            acc_ctl.negate = side_ff;
            if (side_ff) begin
               state_in = ST_SCALE;
            end else begin
               side_in  = 1'b1;
               state_in = ST_YEAR;
            end
         end
         ST_SCALE: begin
            acc_ctl.scale = 1'b1;
            side_in       = 1'b0;
            state_in      = ST_TIME;
         end
         ST_TIME: begin
            term = TermWidth'(hour) * TermWidth'(SecsPerHour)
                 + TermWidth'(minute) * TermWidth'(6'd60) + TermWidth'(second);
            acc_ctl.add    = 1'b1;
            acc_ctl.negate = side_ff;
            if (side_ff) begin
               state_in = ST_DONE;
            end else begin
               side_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mag        = acc[AccWidth-1] ? AccWidth'(-acc) : AccWidth'(acc);
      first_key  = {item_ff.first_year, item_ff.first_month, item_ff.first_day,
                    item_ff.first_hour, item_ff.first_minute, item_ff.first_second};
      second_key = {item_ff.second_year, item_ff.second_month, item_ff.second_day,
                    item_ff.second_hour, item_ff.second_minute, item_ff.second_second};
      priority if (mag < AccWidth'(deadband_ff)) begin
         rsp_data_in.seconds_difference = '0;
      end else if (acc > DiffMax) begin
         rsp_data_in.seconds_difference = DiffMax[32:0];
      end else if (acc < DiffMin) begin
         rsp_data_in.seconds_difference = DiffMin[32:0];
      end else begin
         rsp_data_in.seconds_difference = acc[32:0];
      end
      priority if (first_key > second_key) begin
         rsp_data_in.order = OrderFirstLater;
      end else if (first_key < second_key) begin
         rsp_data_in.order = OrderSecondLater;
      end else begin
         rsp_data_in.order = OrderEqual;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= 1'b0;
         leap_ff      <= 1'b0;
         quot_ff      <= '0;
         deadband_ff  <= DeadbandReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         leap_ff  <= leap_in;
         quot_ff  <= quot_in;
         if (csr_wr_en) begin
            deadband_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         item_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rsp_mag = rsp_data_ff.seconds_difference[32] ?
                    33'(-rsp_data_ff.seconds_difference) : rsp_data_ff.seconds_difference;

   a_equal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.order == OrderEqual) |->
         (rsp_data_ff.seconds_difference == '0))
      else $error("Equal timestamps gave a nonzero difference.");

   a_deadband: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.seconds_difference != '0) |->
         (rsp_mag >= 33'(deadband_ff)))
      else $error("A nonzero difference lies inside the deadband.");

   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && rsp_valid_ff && rsp_stall |=> (state_ff == ST_DONE))
      else $error("A pending result was overwritten.");

   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> (state_ff == ST_YEAR) && !side_ff)
      else $error("An input transfer did not start the sequence.");

endmodule

### bench/timestamp_difference_seconds_tb.sv
module timestamp_difference_seconds_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tds_pkg::*;

   class difference_ledger;
      bit [7:0]    deadband;
      int          errors;
      tds_rsp_type expected_q[$];

      function new();
         deadband = DeadbandReset;
         errors = 0;
      endfunction

      static function bit is_leap(longint year);
         return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      endfunction

      static function longint days_in_month(longint year, longint month);
         case (month)
            2: begin
               return is_leap(year) ? 29 : 28;
            end
            4, 6, 9, 11: begin
               return 30;
            end
            default: begin
               return 31;
            end
         endcase
      endfunction

      // Linear count of seconds since the start of year zero, year zero being a leap year.
      function longint stamp_seconds(logic [37:0] t);
         longint year;
         longint whole_months;
         longint days;
         year = longint'(t[37:26]);
         whole_months = (t[25:22] == 0) ? 0 : longint'(t[25:22]) - 1;
         if (whole_months > 12) begin
            whole_months = 12;
         end
         days = 365 * year + (year + 3) / 4 - (year + 99) / 100 + (year + 399) / 400;
         days += longint'(t[21:17]);
         for (longint m = 1; m <= whole_months; m++) begin
            days += days_in_month(year, m);
         end
         return days * 86400 + longint'(t[16:12]) * 3600 + longint'(t[11:6]) * 60
                + longint'(t[5:0]);
      endfunction

      function tds_rsp_type predict_difference(tds_req_type r);
         logic [37:0] first_stamp;
         logic [37:0] second_stamp;
         longint      diff;
         longint      magnitude;
         tds_rsp_type predicted;
         first_stamp = r[75:38];
         second_stamp = r[37:0];
         diff = stamp_seconds(second_stamp) - stamp_seconds(first_stamp);
         magnitude = (diff < 0) ? -diff : diff;
         if (magnitude < longint'(deadband)) begin
            diff = 0;
         end
         if (diff > 64'sd4294967295) begin
            diff = 64'sd4294967295;
         end
         if (diff < -64'sd4294967296) begin
            diff = -64'sd4294967296;
         end
         predicted.seconds_difference = diff[32:0];
         if (first_stamp > second_stamp) begin
            predicted.order = OrderFirstLater;
         end else if (first_stamp < second_stamp) begin
            predicted.order = OrderSecondLater;
         end else begin
            predicted.order = OrderEqual;
         end
         return predicted;
      endfunction

      function void note_request(tds_req_type r);
         expected_q.push_back(predict_difference(r));
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(tds_rsp_type got);
         tds_rsp_type want;
         if (expected_q.size() == 0) begin
            report("result transfer with no result expected");
         end else begin
            want = expected_q.pop_front();
            if (got.seconds_difference !== want.seconds_difference) begin
               report($sformatf("seconds_difference expected %0d got %0d",
                                want.seconds_difference, got.seconds_difference));
            end
            if (got.order !== want.order) begin
               report($sformatf("order expected %0d got %0d", want.order, got.order));
            end
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tds_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tds_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   difference_ledger ledger = new();
   bit gaps_on = 1'b1;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;

   timestamp_difference_seconds dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // The result side stalls at random, and for a long stretch whenever a hold is requested.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ledger.check_result(rsp_data);
      end
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(99) < 29);
      end
   end

   function automatic logic [37:0] stamp(int year, int month, int day, int hour,
                                         int minute, int second);
      return {12'(year), 4'(month), 5'(day), 5'(hour), 6'(minute), 6'(second)};
   endfunction

   function automatic logic [37:0] valid_stamp();
      int year;
      int month;
      year = $urandom_range(2000, 2099);
      month = $urandom_range(1, 12);
      return stamp(year, month,
                   $urandom_range(1, int'(difference_ledger::days_in_month(year, month))),
                   $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
   endfunction

   // Mostly real dates, many of them close together so that the deadband matters,
   // and some raw bit patterns that reach every field value.
   function automatic tds_req_type random_request();
      logic [37:0] first_stamp;
      logic [37:0] second_stamp;
      logic [95:0] raw;
      int          pick;
      pick = $urandom_range(99);
      first_stamp = valid_stamp();
      second_stamp = valid_stamp();
      if (pick >= 85) begin
         raw = {$urandom, $urandom, $urandom};
         return raw[75:0];
      end
      if (pick >= 60) begin
         second_stamp = first_stamp;
         second_stamp[5:0] = 6'($urandom_range(0, 59));
         if ($urandom_range(1)) begin
            second_stamp[11:6] = 6'($urandom_range(0, 59));
         end
         if (pick >= 75) begin
            second_stamp[16:12] = 5'($urandom_range(0, 23));
         end
      end
      if ($urandom_range(1)) begin
         return {second_stamp, first_stamp};
      end
      return {first_stamp, second_stamp};
   endfunction

   task automatic send(input tds_req_type r);
      while (gaps_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(posedge clock);
      end while (req_stall);
      ledger.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic set_deadband(input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.deadband = value;
   endtask

   task automatic run_random(input int count);
      repeat (count) send(random_request());
   endtask

   initial begin
      tds_req_type directed[$];
      directed.push_back({stamp(2024, 6, 15, 12, 30, 45), stamp(2024, 6, 15, 12, 30, 45)});
      directed.push_back({stamp(2000, 1, 1, 0, 0, 0), stamp(2099, 12, 31, 23, 59, 59)});
      directed.push_back({stamp(2099, 12, 31, 23, 59, 59), stamp(2000, 1, 1, 0, 0, 0)});
      directed.push_back({stamp(2000, 2, 28, 0, 0, 0), stamp(2000, 3, 1, 0, 0, 0)});
      directed.push_back({stamp(2100, 2, 28, 0, 0, 0), stamp(2100, 3, 1, 0, 0, 0)});
      directed.push_back({stamp(2023, 12, 31, 23, 59, 59), stamp(2024, 1, 1, 0, 0, 0)});
      directed.push_back({stamp(2024, 1, 1, 0, 0, 0), stamp(2024, 1, 1, 0, 0, 10)});
      directed.push_back({stamp(2024, 1, 1, 0, 0, 9), stamp(2024, 1, 1, 0, 0, 0)});
      directed.push_back({stamp(2020, 0, 5, 0, 0, 0), stamp(2020, 1, 5, 0, 0, 0)});
      directed.push_back({stamp(2021, 13, 1, 0, 0, 0), stamp(2021, 15, 1, 0, 0, 0)});
      directed.push_back({stamp(2021, 12, 31, 0, 0, 0), stamp(2021, 13, 1, 0, 0, 0)});
      directed.push_back({stamp(2022, 2, 31, 0, 0, 0), stamp(2022, 3, 1, 0, 0, 0)});
      directed.push_back({stamp(2030, 1, 0, 31, 63, 63), stamp(2030, 1, 1, 0, 0, 0)});
      directed.push_back({stamp(0, 0, 0, 0, 0, 0), stamp(4095, 15, 31, 31, 63, 63)});
      directed.push_back({stamp(4095, 15, 31, 31, 63, 63), stamp(0, 0, 0, 0, 0, 0)});
      directed.push_back({stamp(1999, 12, 31, 23, 59, 59), stamp(2000, 1, 1, 0, 0, 0)});
      directed.push_back({stamp(2099, 12, 31, 23, 59, 59), stamp(2100, 1, 1, 0, 0, 0)});
      directed.push_back({stamp(2000, 2, 29, 12, 0, 0), stamp(2001, 2, 28, 12, 0, 0)});
      directed.push_back({stamp(2000, 1, 1, 0, 0, 0), stamp(2136, 2, 7, 6, 28, 15)});
      directed.push_back({stamp(2136, 2, 7, 6, 28, 16), stamp(2000, 1, 1, 0, 0, 0)});
      directed.push_back({stamp(0, 0, 0, 0, 0, 0), stamp(0, 0, 0, 0, 0, 0)});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         send(directed[i]);
      end
      drain();
      set_deadband(8'd0);
      run_random(300);
      drain();
      // The result side holds off while the sender keeps offering, so the input stalls.
      set_deadband(8'd255);
      hold_token <= hold_token + 1;
      run_random(300);
      drain();
      set_deadband(8'd1);
      gaps_on = 1'b0;
      run_random(350);
      gaps_on = 1'b1;
      drain();
      set_deadband(8'($urandom_range(2, 254)));
      run_random(400);
      drain();
      repeat (20) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
